// ----- design/grmm_pkg.sv -----
// Package for the grid row/column min, max and average block.
// Holds widths, result codes, controller states and command/status structs.
// No dependencies.
package grmm_pkg;

	localparam int SAMPLE_W = 16;
	localparam int MAX_COLS = 32;
	localparam int MAX_ROWS = 64;
	localparam int COL_W    = 5;
	localparam int ROW_W    = 6;
	localparam int NROWS_W  = 7;
	localparam int NCOLS_W  = 6;
	localparam int INDEX_W  = 6;
	localparam int KIND_W   = 2;

	localparam int ROW_TOT_W  = 21;
	localparam int COL_TOT_W  = 22;
	localparam int GRID_TOT_W = 27;
	localparam int ENTRY_W    = 2 * SAMPLE_W + COL_TOT_W;

	localparam int DIVD_W     = GRID_TOT_W;
	localparam int DIVR_W     = 12;
	localparam int QUO_W      = SAMPLE_W;
	localparam int STEP_W     = 4;

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 7;

	localparam logic [CFG_IDX_W-1:0] REG_NUM_ROWS = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_NUM_COLS = 1'd1;

	localparam logic [NROWS_W-1:0] NUM_ROWS_RST = 7'd64;
	localparam logic [NCOLS_W-1:0] NUM_COLS_RST = 6'd32;

	localparam logic [KIND_W-1:0] KIND_ROW  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_COL  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_GRID = 2'd2;

	typedef enum logic [1:0] {
		SEL_ROW,
		SEL_COL,
		SEL_GRID
	} res_sel_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_UPD,
		ST_RLD,
		ST_RDIV,
		ST_ROUT,
		ST_CRD,
		ST_CLD,
		ST_CDIV,
		ST_COUT,
		ST_GLD,
		ST_GDIV,
		ST_GOUT
	} state_t;

	typedef struct packed {
		logic     accept;
		logic     upd;
		logic     col_rd;
		logic     div_start;
		logic     out_load;
		res_sel_t sel;
		logic     j_clr;
		logic     j_inc;
	} cmd_t;

	typedef struct packed {
		logic row_end;
		logic grid_end;
		logic div_busy;
		logic j_last;
		logic out_free;
	} status_t;

endpackage

// ----- design/grmm_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module grmm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- design/grmm_div.sv -----
// Sequential signed divider, one quotient bit per cycle, truncating toward zero.
// The quotient magnitude must fit in QUO_W bits. Uses grmm_pkg.
module grmm_div (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	input  logic signed [grmm_pkg::DIVD_W-1:0]    dividend,
	input  logic        [grmm_pkg::DIVR_W-1:0]    divisor,
	output logic                                  busy,
	output logic        [grmm_pkg::QUO_W-1:0]     quotient
);

	logic                          busy_q;
	logic [grmm_pkg::STEP_W-1:0]   step_q;
	logic [grmm_pkg::DIVD_W-1:0]   rem_q;
	logic [grmm_pkg::DIVR_W-1:0]   dvs_q;
	logic [grmm_pkg::QUO_W-1:0]    quo_q;
	logic                          neg_q;
	logic [grmm_pkg::DIVD_W-1:0]   mag;
	logic [grmm_pkg::DIVD_W-1:0]   shifted;

	assign mag      = dividend[grmm_pkg::DIVD_W-1] ? -dividend : dividend;
	assign shifted  = {{(grmm_pkg::DIVD_W-grmm_pkg::DIVR_W){1'b0}}, dvs_q} << step_q;
	assign busy     = busy_q;
	assign quotient = neg_q ? -quo_q : quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			step_q <= grmm_pkg::STEP_W'(grmm_pkg::QUO_W - 1);
		end else if (busy_q) begin
			if (step_q == '0) begin
				busy_q <= 1'b0;
			end else begin
				step_q <= step_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= mag;
			dvs_q <= divisor;
			neg_q <= dividend[grmm_pkg::DIVD_W-1];
			quo_q <= '0;
		end else if (busy_q && rem_q >= shifted) begin
			rem_q         <= rem_q - shifted;
			quo_q[step_q] <= 1'b1;
		end
	end

endmodule

// ----- design/grmm_ctrl.sv -----
// Controller state machine: sequences sample update, divisions and result output.
// Drives the datapath through cmd_t and reads status_t. Uses grmm_pkg.
module grmm_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  grmm_pkg::status_t   status,
	output grmm_pkg::cmd_t      cmd
);

	grmm_pkg::state_t state_q;
	grmm_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= grmm_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			grmm_pkg::ST_IDLE: if (in_valid) state_d = grmm_pkg::ST_UPD;
			grmm_pkg::ST_UPD:  state_d = status.row_end ? grmm_pkg::ST_RLD : grmm_pkg::ST_IDLE;
			grmm_pkg::ST_RLD:  state_d = grmm_pkg::ST_RDIV;
			grmm_pkg::ST_RDIV: if (!status.div_busy) state_d = grmm_pkg::ST_ROUT;
			grmm_pkg::ST_ROUT: begin
				if (status.out_free) begin
					state_d = status.grid_end ? grmm_pkg::ST_CRD : grmm_pkg::ST_IDLE;
				end
			end
			grmm_pkg::ST_CRD:  state_d = grmm_pkg::ST_CLD;
			grmm_pkg::ST_CLD:  state_d = grmm_pkg::ST_CDIV;
			grmm_pkg::ST_CDIV: if (!status.div_busy) state_d = grmm_pkg::ST_COUT;
			grmm_pkg::ST_COUT: begin
				if (status.out_free) begin
					state_d = status.j_last ? grmm_pkg::ST_GLD : grmm_pkg::ST_CRD;
				end
			end
			grmm_pkg::ST_GLD:  state_d = grmm_pkg::ST_GDIV;
			grmm_pkg::ST_GDIV: if (!status.div_busy) state_d = grmm_pkg::ST_GOUT;
			grmm_pkg::ST_GOUT: if (status.out_free) state_d = grmm_pkg::ST_IDLE;
			default:           state_d = grmm_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready      = 1'b0;
		cmd           = '0;
		cmd.sel       = grmm_pkg::SEL_ROW;
		case (state_q)
			grmm_pkg::ST_IDLE: begin
				in_ready   = 1'b1;
				cmd.accept = in_valid;
			end
			grmm_pkg::ST_UPD: cmd.upd = 1'b1;
			grmm_pkg::ST_RLD: cmd.div_start = 1'b1;
			grmm_pkg::ST_ROUT: begin
				cmd.out_load = status.out_free;
				cmd.j_clr    = status.out_free;
			end
			grmm_pkg::ST_CRD: cmd.col_rd = 1'b1;
			grmm_pkg::ST_CLD: begin
				cmd.sel       = grmm_pkg::SEL_COL;
				cmd.div_start = 1'b1;
			end
			grmm_pkg::ST_COUT: begin
				cmd.sel      = grmm_pkg::SEL_COL;
				cmd.out_load = status.out_free;
				cmd.j_inc    = status.out_free && !status.j_last;
			end
			grmm_pkg::ST_GLD: begin
				cmd.sel       = grmm_pkg::SEL_GRID;
				cmd.div_start = 1'b1;
			end
			grmm_pkg::ST_GOUT: begin
				cmd.sel      = grmm_pkg::SEL_GRID;
				cmd.out_load = status.out_free;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

endmodule

// ----- design/grmm_dp.sv -----
// Datapath: configuration, counters, running statistics, column store,
// divider and output register. Uses grmm_pkg, grmm_ram and grmm_div.
module grmm_dp (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    cfg_we,
	input  logic        [grmm_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic        [grmm_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic signed [grmm_pkg::SAMPLE_W-1:0]    sample,
	input  grmm_pkg::cmd_t                          cmd,
	output grmm_pkg::status_t                       status,
	output logic                                    out_valid,
	input  logic                                    out_ready,
	output logic        [grmm_pkg::KIND_W-1:0]      kind,
	output logic        [grmm_pkg::INDEX_W-1:0]     index,
	output logic signed [grmm_pkg::SAMPLE_W-1:0]    min_value,
	output logic signed [grmm_pkg::SAMPLE_W-1:0]    max_value,
	output logic signed [grmm_pkg::SAMPLE_W-1:0]    avg_value,
	output logic                                    last
);

	localparam int SW = grmm_pkg::SAMPLE_W;

	logic        [grmm_pkg::NROWS_W-1:0]    num_rows_q;
	logic        [grmm_pkg::NCOLS_W-1:0]    num_cols_q;
	logic        [grmm_pkg::NROWS_W-1:0]    rows_c;
	logic        [grmm_pkg::NCOLS_W-1:0]    cols_c;
	logic        [grmm_pkg::ROW_W-1:0]      row_cnt_q;
	logic        [grmm_pkg::COL_W-1:0]      col_cnt_q;
	logic        [grmm_pkg::COL_W-1:0]      j_q;
	logic        [grmm_pkg::ROW_W-1:0]      row_idx_q;
	logic                                   grid_end_q;
	logic                                   row_end;
	logic                                   grid_end;

	logic signed [SW-1:0]                   sample_q;
	logic signed [SW-1:0]                   row_min_q;
	logic signed [SW-1:0]                   row_max_q;
	logic signed [grmm_pkg::ROW_TOT_W-1:0]  row_tot_q;
	logic signed [SW-1:0]                   grid_min_q;
	logic signed [SW-1:0]                   grid_max_q;
	logic signed [grmm_pkg::GRID_TOT_W-1:0] grid_tot_q;

	logic        [grmm_pkg::ENTRY_W-1:0]    rd_entry;
	logic        [grmm_pkg::ENTRY_W-1:0]    wr_entry;
	logic signed [SW-1:0]                   ent_min;
	logic signed [SW-1:0]                   ent_max;
	logic signed [grmm_pkg::COL_TOT_W-1:0]  ent_tot;
	logic signed [SW-1:0]                   new_cmin;
	logic signed [SW-1:0]                   new_cmax;
	logic signed [grmm_pkg::COL_TOT_W-1:0]  new_ctot;
	logic                                   first_col;
	logic                                   first_row;

	logic signed [grmm_pkg::DIVD_W-1:0]     div_dividend;
	logic        [grmm_pkg::DIVR_W-1:0]     div_divisor;
	logic        [grmm_pkg::DIVR_W-1:0]     cell_count;
	logic                                   div_busy;
	logic        [grmm_pkg::QUO_W-1:0]      quotient;

	logic                                   out_valid_q;

	assign rows_c = (num_rows_q == '0) ? grmm_pkg::NROWS_W'(1) :
		(num_rows_q > grmm_pkg::NROWS_W'(grmm_pkg::MAX_ROWS)) ?
		grmm_pkg::NROWS_W'(grmm_pkg::MAX_ROWS) : num_rows_q;
	assign cols_c = (num_cols_q == '0) ? grmm_pkg::NCOLS_W'(1) :
		(num_cols_q > grmm_pkg::NCOLS_W'(grmm_pkg::MAX_COLS)) ?
		grmm_pkg::NCOLS_W'(grmm_pkg::MAX_COLS) : num_cols_q;

	assign first_col = (col_cnt_q == '0);
	assign first_row = (row_cnt_q == '0);
	assign row_end   = ({1'b0, col_cnt_q} + grmm_pkg::NCOLS_W'(1)) >= cols_c;
	assign grid_end  = ({1'b0, row_cnt_q} + grmm_pkg::NROWS_W'(1)) >= rows_c;

	assign status.row_end  = row_end;
	assign status.grid_end = grid_end_q;
	assign status.div_busy = div_busy;
	assign status.j_last   = ({1'b0, j_q} + grmm_pkg::NCOLS_W'(1)) >= cols_c;
	assign status.out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_rows_q <= grmm_pkg::NUM_ROWS_RST;
			num_cols_q <= grmm_pkg::NUM_COLS_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				grmm_pkg::REG_NUM_ROWS: num_rows_q <= cfg_data;
				grmm_pkg::REG_NUM_COLS: num_cols_q <= cfg_data[grmm_pkg::NCOLS_W-1:0];
				default: num_rows_q <= num_rows_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_cnt_q  <= '0;
			col_cnt_q  <= '0;
			j_q        <= '0;
			grid_end_q <= 1'b0;
		end else begin
			if (cmd.upd) begin
				grid_end_q <= row_end && grid_end;
				if (!row_end) begin
					col_cnt_q <= col_cnt_q + 1'b1;
				end else if (!grid_end) begin
					row_cnt_q <= row_cnt_q + 1'b1;
					col_cnt_q <= '0;
				end else begin
					row_cnt_q <= '0;
					col_cnt_q <= '0;
				end
			end
			if (cmd.j_clr) begin
				j_q <= '0;
			end else if (cmd.j_inc) begin
				j_q <= j_q + 1'b1;
			end
		end
	end

	assign ent_min = rd_entry[grmm_pkg::ENTRY_W-1 -: SW];
	assign ent_max = rd_entry[grmm_pkg::COL_TOT_W + SW - 1 -: SW];
	assign ent_tot = rd_entry[grmm_pkg::COL_TOT_W-1:0];

	always_comb begin
		if (first_row) begin
			new_cmin = sample_q;
			new_cmax = sample_q;
			new_ctot = {{(grmm_pkg::COL_TOT_W-SW){sample_q[SW-1]}}, sample_q};
		end else begin
			new_cmin = (sample_q < ent_min) ? sample_q : ent_min;
			new_cmax = (sample_q > ent_max) ? sample_q : ent_max;
			new_ctot = ent_tot + {{(grmm_pkg::COL_TOT_W-SW){sample_q[SW-1]}}, sample_q};
		end
	end

	assign wr_entry = {new_cmin, new_cmax, new_ctot};

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			sample_q <= sample;
		end
		if (cmd.upd) begin
			row_idx_q <= row_cnt_q;
			if (first_col) begin
				row_min_q <= sample_q;
				row_max_q <= sample_q;
				row_tot_q <= {{(grmm_pkg::ROW_TOT_W-SW){sample_q[SW-1]}}, sample_q};
			end else begin
				row_min_q <= (sample_q < row_min_q) ? sample_q : row_min_q;
				row_max_q <= (sample_q > row_max_q) ? sample_q : row_max_q;
				row_tot_q <= row_tot_q +
					{{(grmm_pkg::ROW_TOT_W-SW){sample_q[SW-1]}}, sample_q};
			end
			if (first_col && first_row) begin
				grid_min_q <= sample_q;
				grid_max_q <= sample_q;
				grid_tot_q <= {{(grmm_pkg::GRID_TOT_W-SW){sample_q[SW-1]}}, sample_q};
			end else begin
				grid_min_q <= (sample_q < grid_min_q) ? sample_q : grid_min_q;
				grid_max_q <= (sample_q > grid_max_q) ? sample_q : grid_max_q;
				grid_tot_q <= grid_tot_q +
					{{(grmm_pkg::GRID_TOT_W-SW){sample_q[SW-1]}}, sample_q};
			end
		end
	end

	grmm_ram #(
		.WIDTH(grmm_pkg::ENTRY_W),
		.DEPTH(grmm_pkg::MAX_COLS)
	) u_col_ram (
		.clk   (clk),
		.we    (cmd.upd),
		.waddr (col_cnt_q),
		.wdata (wr_entry),
		.re    (cmd.accept || cmd.col_rd),
		.raddr (cmd.col_rd ? j_q : col_cnt_q),
		.rdata (rd_entry)
	);

	assign cell_count = grmm_pkg::DIVR_W'(rows_c) * grmm_pkg::DIVR_W'(cols_c);

	always_comb begin
		case (cmd.sel)
			grmm_pkg::SEL_ROW: begin
				div_dividend = {{(grmm_pkg::DIVD_W-grmm_pkg::ROW_TOT_W){row_tot_q[
					grmm_pkg::ROW_TOT_W-1]}}, row_tot_q};
				div_divisor  = grmm_pkg::DIVR_W'(cols_c);
			end
			grmm_pkg::SEL_COL: begin
				div_dividend = {{(grmm_pkg::DIVD_W-grmm_pkg::COL_TOT_W){ent_tot[
					grmm_pkg::COL_TOT_W-1]}}, ent_tot};
				div_divisor  = grmm_pkg::DIVR_W'(rows_c);
			end
			default: begin
				div_dividend = grid_tot_q;
				div_divisor  = cell_count;
			end
		endcase
	end

	grmm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.busy     (div_busy),
		.quotient (quotient)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			avg_value <= quotient;
			case (cmd.sel)
				grmm_pkg::SEL_ROW: begin
					kind      <= grmm_pkg::KIND_ROW;
					index     <= row_idx_q;
					min_value <= row_min_q;
					max_value <= row_max_q;
					last      <= !grid_end_q;
				end
				grmm_pkg::SEL_COL: begin
					kind      <= grmm_pkg::KIND_COL;
					index     <= {1'b0, j_q};
					min_value <= ent_min;
					max_value <= ent_max;
					last      <= 1'b0;
				end
				default: begin
					kind      <= grmm_pkg::KIND_GRID;
					index     <= '0;
					min_value <= grid_min_q;
					max_value <= grid_max_q;
					last      <= 1'b1;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ----- design/grid_row_col_min_max_avg.sv -----
// Top level of the grid row/column min, max and average block.
// Joins grmm_ctrl and grmm_dp; uses grmm_pkg.
//
//   Channel  Direction  Handshake            Payload
//   cfg      in         cfg_we               cfg_index, cfg_data
//   in       in         in_valid / in_ready  sample
//   out      out        out_valid/out_ready  kind, index, min/max/avg_value, last
//
// An item ending no row is accepted and applied; one ending a row also runs its row
// average through the 16-step shift-subtract divider, as do each column and then the
// grid after the last row. A result waits in the output register while the next item
// is accepted. Reset zeroes the counters, loads the default row and column counts and
// drops the output valid; there is no clearing pass. A stalled output holds the sequence.
module grid_row_col_min_max_avg (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    cfg_we,
	input  logic        [grmm_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic        [grmm_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                                    in_valid,
	output logic                                    in_ready,
	input  logic signed [grmm_pkg::SAMPLE_W-1:0]    sample,
	output logic                                    out_valid,
	input  logic                                    out_ready,
	output logic        [grmm_pkg::KIND_W-1:0]      kind,
	output logic        [grmm_pkg::INDEX_W-1:0]     index,
	output logic signed [grmm_pkg::SAMPLE_W-1:0]    min_value,
	output logic signed [grmm_pkg::SAMPLE_W-1:0]    max_value,
	output logic signed [grmm_pkg::SAMPLE_W-1:0]    avg_value,
	output logic                                    last
);

	grmm_pkg::cmd_t    cmd;
	grmm_pkg::status_t status;

	grmm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	grmm_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.sample    (sample),
		.cmd       (cmd),
		.status    (status),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.kind      (kind),
		.index     (index),
		.min_value (min_value),
		.max_value (max_value),
		.avg_value (avg_value),
		.last      (last)
	);

endmodule

// ----- test/tb_grid_row_col_min_max_avg.sv -----
// Testbench for grid_row_col_min_max_avg: streams grids of samples through the block under
// changing row and column counts and checks every row, column and whole-grid result.
// Depends on grmm_pkg and the block's RTL only.
module tb_grid_row_col_min_max_avg;
	timeunit 1ns;
	timeprecision 1ps;

	import grmm_pkg::*;

	localparam int CFG_QUIET  = 48;
	localparam int IDLE_LIMIT = 4000;
	localparam int ITEM_GOAL  = 320;

	class grid_stats_board;
		typedef struct {
			logic [KIND_W-1:0]          kind;
			logic [INDEX_W-1:0]         index;
			logic signed [SAMPLE_W-1:0] min_value;
			logic signed [SAMPLE_W-1:0] max_value;
			logic signed [SAMPLE_W-1:0] avg_value;
			logic                       last;
		} stat_rec_t;

		logic [NROWS_W-1:0] rows_reg;
		logic [NCOLS_W-1:0] cols_reg;
		int unsigned        row_cnt;
		int unsigned        col_cnt;
		int unsigned        first_row_width;
		longint             row_min, row_max, row_sum;
		longint             col_min[MAX_COLS];
		longint             col_max[MAX_COLS];
		longint             col_sum[MAX_COLS];
		longint             grid_min, grid_max, grid_sum;
		stat_rec_t          pending[$];
		int                 errors;
		int                 samples;
		int                 rows_done;
		int                 cols_done;
		int                 grids_done;

		function new();
			rows_reg = NUM_ROWS_RST;
			cols_reg = NUM_COLS_RST;
		endfunction

		function int unsigned eff_rows();
			if (rows_reg == 0)
				return 1;
			if (rows_reg > MAX_ROWS)
				return MAX_ROWS;
			return rows_reg;
		endfunction

		function int unsigned eff_cols();
			if (cols_reg == 0)
				return 1;
			if (cols_reg > MAX_COLS)
				return MAX_COLS;
			return cols_reg;
		endfunction

		function bit mid_grid();
			return row_cnt != 0 || col_cnt != 0;
		endfunction

		// Past the first row, only columns written in that row may be read back.
		function int unsigned cols_ceiling();
			return (row_cnt == 0) ? 12 : first_row_width;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
			if (idx == REG_NUM_ROWS)
				rows_reg = val[NROWS_W-1:0];
			else
				cols_reg = val[NCOLS_W-1:0];
		endfunction

		function void push_stat(logic [KIND_W-1:0] k, int unsigned idx, longint mn, longint mx,
				longint avg, logic lst);
			stat_rec_t r;
			r.kind      = k;
			r.index     = idx[INDEX_W-1:0];
			r.min_value = mn[SAMPLE_W-1:0];
			r.max_value = mx[SAMPLE_W-1:0];
			r.avg_value = avg[SAMPLE_W-1:0];
			r.last      = lst;
			pending.push_back(r);
		endfunction

		function void note_sample(logic signed [SAMPLE_W-1:0] s);
			int unsigned rows;
			int unsigned cols;
			int unsigned c;
			longint      v;
			bit          grid_end;
			rows = eff_rows();
			cols = eff_cols();
			c = (col_cnt >= MAX_COLS) ? MAX_COLS - 1 : col_cnt;
			v = longint'(s);
			samples++;

			if (col_cnt == 0) begin
				row_min = v;
				row_max = v;
				row_sum = v;
			end else begin
				if (v < row_min) row_min = v;
				if (v > row_max) row_max = v;
				row_sum += v;
			end

			if (row_cnt == 0 && col_cnt == 0) begin
				grid_min = v;
				grid_max = v;
				grid_sum = v;
				first_row_width = 0;
			end else begin
				if (v < grid_min) grid_min = v;
				if (v > grid_max) grid_max = v;
				grid_sum += v;
			end

			if (row_cnt == 0) begin
				col_min[c] = v;
				col_max[c] = v;
				col_sum[c] = v;
				if (c + 1 > first_row_width)
					first_row_width = c + 1;
			end else begin
				if (v < col_min[c]) col_min[c] = v;
				if (v > col_max[c]) col_max[c] = v;
				col_sum[c] += v;
			end

			if (col_cnt + 1 < cols) begin
				col_cnt++;
				return;
			end

			grid_end = (row_cnt + 1 >= rows);
			push_stat(KIND_ROW, row_cnt, row_min, row_max, row_sum / longint'(cols), !grid_end);
			if (!grid_end) begin
				row_cnt++;
				col_cnt = 0;
				return;
			end
			for (int unsigned j = 0; j < cols; j++)
				push_stat(KIND_COL, j, col_min[j], col_max[j], col_sum[j] / longint'(rows), 1'b0);
			push_stat(KIND_GRID, 0, grid_min, grid_max,
				grid_sum / (longint'(rows) * longint'(cols)), 1'b1);
			row_cnt = 0;
			col_cnt = 0;
		endfunction

		function void report(string field, logic signed [31:0] expd, logic signed [31:0] act);
			errors++;
			$display("%0t: %s expected %0d actual %0d", $time, field, expd, act);
		endfunction

		function void check_result(logic [KIND_W-1:0] k, logic [INDEX_W-1:0] idx,
				logic signed [SAMPLE_W-1:0] mn, logic signed [SAMPLE_W-1:0] mx,
				logic signed [SAMPLE_W-1:0] av, logic lst);
			stat_rec_t e;
			if (pending.size() == 0) begin
				errors++;
				$display("%0t: result kind %0d index %0d arrived with none expected",
					$time, k, idx);
				return;
			end
			e = pending.pop_front();
			if (k !== e.kind) report("kind", e.kind, k);
			if (idx !== e.index) report("index", e.index, idx);
			if (mn !== e.min_value) report("min_value", e.min_value, mn);
			if (mx !== e.max_value) report("max_value", e.max_value, mx);
			if (av !== e.avg_value) report("avg_value", e.avg_value, av);
			if (lst !== e.last) report("last", e.last, lst);
			case (e.kind)
				KIND_ROW: rows_done++;
				KIND_COL: cols_done++;
				default:  grids_done++;
			endcase
		endfunction
	endclass

	logic                       clk;
	logic                       arst_n;
	logic                       cfg_we;
	logic [CFG_IDX_W-1:0]       cfg_index;
	logic [CFG_DATA_W-1:0]      cfg_data;
	logic                       in_valid;
	logic                       in_ready;
	logic signed [SAMPLE_W-1:0] sample;
	logic                       out_valid;
	logic                       out_ready;
	logic [KIND_W-1:0]          kind;
	logic [INDEX_W-1:0]         index;
	logic signed [SAMPLE_W-1:0] min_value;
	logic signed [SAMPLE_W-1:0] max_value;
	logic signed [SAMPLE_W-1:0] avg_value;
	logic                       last;

	grid_stats_board sb;
	bit              in_no_gaps;
	bit              out_no_stall;
	int              quiet_cycles;

	grid_row_col_min_max_avg u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.sample    (sample),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.kind      (kind),
		.index     (index),
		.min_value (min_value),
		.max_value (max_value),
		.avg_value (avg_value),
		.last      (last)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic logic signed [SAMPLE_W-1:0] draw_sample();
		int unsigned pick;
		int          v;
		pick = $urandom_range(0, 15);
		if (pick < 2)
			return {1'b1, {(SAMPLE_W-1){1'b0}}};
		if (pick < 4)
			return {1'b0, {(SAMPLE_W-1){1'b1}}};
		if (pick < 8) begin
			v = int'($urandom_range(0, 8)) - 4;
			return v[SAMPLE_W-1:0];
		end
		v = $urandom();
		return v[SAMPLE_W-1:0];
	endfunction

	task automatic send_sample(input logic signed [SAMPLE_W-1:0] s);
		int unsigned gap;
		gap = in_no_gaps ? 0 : $urandom_range(0, 4);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		sample   <= s;
		do @(posedge clk); while (in_ready !== 1'b1);
		sb.note_sample(s);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.write_reg(idx, val);
		@(posedge clk);
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (CFG_QUIET) @(posedge clk);
	endtask

	initial begin
		int unsigned stall;
		out_ready <= 1'b0;
		@(posedge clk);
		forever begin
			stall = out_no_stall ? 0 : $urandom_range(0, 4);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (out_valid !== 1'b1);
			sb.check_result(kind, index, min_value, max_value, avg_value, last);
			if ($urandom_range(0, 31) == 0)
				out_no_stall = !out_no_stall;
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= IDLE_LIMIT) begin
			$display("%0t: no item moved for %0d cycles", $time, IDLE_LIMIT);
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		int unsigned           grid_no;
		int unsigned           size;
		int unsigned           split;
		int unsigned           sent;
		logic [CFG_DATA_W-1:0] r_val;
		logic [CFG_DATA_W-1:0] c_val;
		sb = new();
		arst_n    <= 1'b0;
		cfg_we    <= 1'b0;
		cfg_index <= REG_NUM_ROWS;
		cfg_data  <= '0;
		in_valid  <= 1'b0;
		sample    <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Zero counts act as a one by one grid.
		write_reg(REG_NUM_ROWS, 7'd0);
		write_reg(REG_NUM_COLS, 7'd0);
		send_sample(16'sh7fff);
		send_sample(16'sh8000);

		// Full-scale values and negative averages that truncate toward zero.
		settle();
		write_reg(REG_NUM_ROWS, 7'd2);
		write_reg(REG_NUM_COLS, 7'd3);
		send_sample(16'sh7fff);
		send_sample(16'sh8000);
		send_sample(-16'sd1);
		send_sample(16'sh8000);
		send_sample(16'sh8000);
		send_sample(-16'sd2);

		// Counts lowered under a running row and a running grid.
		settle();
		write_reg(REG_NUM_ROWS, 7'd3);
		write_reg(REG_NUM_COLS, 7'd4);
		send_sample(16'sd5);
		send_sample(-16'sd7);
		settle();
		write_reg(REG_NUM_COLS, 7'd1);
		send_sample(16'sd9);
		send_sample(-16'sd3);
		settle();
		write_reg(REG_NUM_ROWS, 7'd1);
		send_sample(16'sd4);

		// Column count raised during the first row.
		settle();
		write_reg(REG_NUM_ROWS, 7'd2);
		write_reg(REG_NUM_COLS, 7'd2);
		send_sample(16'sd100);
		settle();
		write_reg(REG_NUM_COLS, 7'd3);
		send_sample(16'sd200);
		send_sample(16'sd300);
		send_sample(-16'sd100);
		send_sample(-16'sd200);
		send_sample(-16'sd300);

		grid_no = 0;
		while (sb.samples < ITEM_GOAL) begin
			settle();
			if (grid_no == 1) begin
				r_val = 7'd127;
				c_val = 7'd1;
			end else if (grid_no == 4) begin
				r_val = 7'd0;
				c_val = 7'd63;
			end else if ($urandom_range(0, 11) == 0) begin
				if ($urandom_range(0, 1)) begin
					r_val = 7'd64;
					c_val = 7'd1;
				end else begin
					r_val = 7'd1;
					c_val = 7'd32;
				end
			end else begin
				r_val = CFG_DATA_W'($urandom_range(0, 6));
				c_val = CFG_DATA_W'($urandom_range(0, 8));
			end
			write_reg(REG_NUM_ROWS, r_val);
			write_reg(REG_NUM_COLS, c_val);
			in_no_gaps = ($urandom_range(0, 3) == 0);
			size = sb.eff_rows() * sb.eff_cols();
			split = (size > 1 && $urandom_range(0, 4) == 0) ? $urandom_range(1, size - 1) : 0;
			sent = 0;
			do begin
				send_sample(draw_sample());
				sent++;
				if (sent == split && sb.mid_grid()) begin
					settle();
					if ($urandom_range(0, 1))
						write_reg(REG_NUM_ROWS,
							CFG_DATA_W'($urandom_range(0, sb.row_cnt + 2)));
					else
						write_reg(REG_NUM_COLS,
							CFG_DATA_W'($urandom_range(0, sb.cols_ceiling())));
				end
			end while (sb.mid_grid());
			grid_no++;
		end
		settle();

		$display("Run covered %0d samples over %0d grids of varying shape.", sb.samples,
			sb.grids_done);
		$display("Checked %0d row, %0d column and %0d grid results.", sb.rows_done,
			sb.cols_done, sb.grids_done);
		if (sb.errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
